>>> sv/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, constants and helpers for the truth table symmetry check.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned MaxInputsDefault  = 10;
  localparam int unsigned MaxOutputsDefault = 4;

  localparam int unsigned WordW    = 64;
  localparam int unsigned InCntW   = 4;
  localparam int unsigned OutCntW  = 3;
  localparam int unsigned VarW     = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned ShiftW   = 6;

  localparam logic [InCntW-1:0]  InputCountRst  = 4'd6;
  localparam logic [OutCntW-1:0] OutputCountRst = 3'd1;
  localparam logic [VarW-1:0]    VarARst        = 4'd1;
  localparam logic [VarW-1:0]    VarBRst        = 4'd0;
  localparam logic [VarW-1:0]    WordVars       = 4'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInputCount   = 3'd0,
    CfgOutputCount  = 3'd1,
    CfgVarA         = 3'd2,
    CfgVarB         = 3'd3,
    CfgOppositePhase = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [WordW-1:0] table_word;
    logic             last_word;
  } in_beat_t;

  typedef struct packed {
    logic symmetric;
    logic bad_query;
  } out_beat_t;

  // minterms where variable k is one, within a 64-bit block
  function automatic logic [WordW-1:0] var_mask(input logic [2:0] k);
    logic [WordW-1:0] m;
    unique case (k)
      3'd0:    m = 64'hAAAA_AAAA_AAAA_AAAA;
      3'd1:    m = 64'hCCCC_CCCC_CCCC_CCCC;
      3'd2:    m = 64'hF0F0_F0F0_F0F0_F0F0;
      3'd3:    m = 64'hFF00_FF00_FF00_FF00;
      3'd4:    m = 64'hFFFF_0000_FFFF_0000;
      3'd5:    m = 64'hFFFF_FFFF_0000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> sv/tts_stream_if.sv
// ----------------------------------------------------------------------------
// tts_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface tts_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> sv/truth_table_symmetry_check.sv
// ----------------------------------------------------------------------------
// truth_table_symmetry_check
// Streams a multi-output truth table one 64-bit block a beat and reports
// whether a chosen variable pair is in-phase or opposite-phase symmetric.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                    | Beats
// in_i    | in  | table_word[63:0], last_word | one per table block
// out_o   | out | symmetric, bad_query       | one per table (on last_word)
// cfg     | in  | cfg_idx_i, cfg_data_i[3:0] | write when cfg_we_i is high
//
// An input beat and its partner block are registered into the compare stage
// and the result into the output register. One block is taken every cycle
// unless in_i stalls, paced by one write and one partner read of the store.
// A partner block is read from the store in the accept cycle and compared in
// the next, so input and store share one stage.
// Reset clears the block counter, the sticky flag and the valid flags and
// loads the config defaults; store contents are not cleared. in_i stalls
// only when a result waits on out_o and a table end holds the compare stage.
// ----------------------------------------------------------------------------
module truth_table_symmetry_check
  import tts_pkg::*;
#(
  parameter int unsigned MaxInputs  = MaxInputsDefault,
  parameter int unsigned MaxOutputs = MaxOutputsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  tts_stream_if.sink          in_i,
  tts_stream_if.source        out_o
);

  localparam int unsigned StoreDepth = (2 ** (MaxInputs - 6)) * MaxOutputs;
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);
  localparam int unsigned AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned NoW        = 5;

  localparam logic [InCntW-1:0] MaxInputsC  = InCntW'(MaxInputs);
  localparam logic [NoW-1:0]    MaxOutputsC = NoW'(MaxOutputs);

  logic [InCntW-1:0]  input_count_q;
  logic [OutCntW-1:0] output_count_q;
  logic [VarW-1:0]    var_a_q, var_b_q;
  logic               opposite_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_count_q  <= InputCountRst;
      output_count_q <= OutputCountRst;
      var_a_q        <= VarARst;
      var_b_q        <= VarBRst;
      opposite_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgInputCount:    input_count_q  <= cfg_data_i;
        CfgOutputCount:   output_count_q <= cfg_data_i[OutCntW-1:0];
        CfgVarA:          var_a_q        <= cfg_data_i;
        CfgVarB:          var_b_q        <= cfg_data_i;
        CfgOppositePhase: opposite_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // derived query settings
  logic [InCntW-1:0] n;
  logic [NoW-1:0]    no;
  logic [InCntW-1:0] blk_sh;
  logic [CntW-1:0]   total, v_mask;
  logic [VarW-1:0]   hi, lo;
  logic              bad;
  logic              lo_hi_word, hi_hi_word;
  logic [CntW-1:0]   mi, mj;

  always_comb begin
    n = (input_count_q > MaxInputsC) ? MaxInputsC : input_count_q;
    no = (output_count_q == '0) ? NoW'(1) : NoW'(output_count_q);
    if (no > MaxOutputsC) no = MaxOutputsC;
    blk_sh = (n > WordVars) ? (n - WordVars) : '0;
    total  = CntW'(no) << blk_sh;
    v_mask = (CntW'(1) << blk_sh) - CntW'(1);
    hi  = (var_a_q > var_b_q) ? var_a_q : var_b_q;
    lo  = (var_a_q > var_b_q) ? var_b_q : var_a_q;
    bad = (var_a_q == var_b_q) || (hi >= n);
    hi_hi_word = (hi >= WordVars);
    lo_hi_word = (lo >= WordVars);
    mi = hi_hi_word ? (CntW'(1) << (hi - WordVars)) : '0;
    mj = lo_hi_word ? (CntW'(1) << (lo - WordVars)) : '0;
  end

  // accept stage: count, store and fetch the partner block
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept, active, cmp_en;
  logic [CntW-1:0] v, partner, later;
  logic            s1_valid_q, s1_last_q, s1_en_q, s1_adv;
  logic [WordW-1:0] s1_word_q, rd_q;

  assign accept = in_i.valid && in_i.ready;
  assign active = (cnt_q < total);
  assign v      = cnt_q & v_mask;
  assign later  = opposite_q ? (mi | mj) : mi;

  always_comb begin
    partner = cnt_q ^ (mi | mj);
    cmp_en  = active && !bad;
    if (lo_hi_word) begin
      cmp_en = cmp_en && ((v & (mi | mj)) == later);
    end else if (hi_hi_word) begin
      cmp_en = cmp_en && ((v & mi) == mi);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (in_i.data.last_word) cnt_d = '0;
      else if (active)         cnt_d = cnt_q + CntW'(1);
    end
  end

  logic [WordW-1:0] store_q [StoreDepth];

  always_ff @(posedge clk_i) begin
    if (accept && active) store_q[cnt_q[AddrW-1:0]] <= in_i.data.table_word;
    if (accept) begin
      rd_q      <= store_q[partner[AddrW-1:0]];
      s1_word_q <= in_i.data.table_word;
      s1_last_q <= in_i.data.last_word;
      s1_en_q   <= cmp_en;
    end
  end

  // compare stage
  logic [WordW-1:0]  diff, lo_m, hi_m, valid_m;
  logic [ShiftW-1:0] sh_lo, sh_in;
  logic              mismatch_q, mismatch_d, mis_now;
  logic              out_valid_q;
  out_beat_t         out_q;

  always_comb begin
    lo_m    = var_mask(lo[2:0]);
    hi_m    = var_mask(hi[2:0]);
    sh_lo   = ShiftW'(1) << lo[2:0];
    sh_in   = opposite_q ? ((ShiftW'(1) << hi[2:0]) + sh_lo)
                         : ((ShiftW'(1) << hi[2:0]) - sh_lo);
    valid_m = (n >= WordVars) ? '1
                              : ({WordW{1'b1}} >> (WordW - (32'd1 << n)));
    if (lo_hi_word) begin
      diff = s1_word_q ^ rd_q;
    end else if (hi_hi_word) begin
      diff = opposite_q ? ((rd_q ^ (s1_word_q >> sh_lo)) & ~lo_m)
                        : ((s1_word_q ^ (rd_q >> sh_lo)) & ~lo_m);
    end else begin
      diff = ((s1_word_q >> sh_in) ^ s1_word_q) & ~hi_m & valid_m &
             (opposite_q ? ~lo_m : lo_m);
    end
    mis_now = mismatch_q || (s1_en_q && (diff != '0));
  end

  assign s1_adv     = s1_valid_q && !(s1_last_q && out_valid_q && !out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign mismatch_d = s1_adv ? (mis_now && !s1_last_q) : mismatch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      mismatch_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      mismatch_q <= mismatch_d;
      if (accept)      s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv && s1_last_q) out_valid_q <= 1'b1;
      else if (out_o.ready)    out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_q.symmetric <= !bad && !mis_now;
      out_q.bad_query <= bad;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_bad_not_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.symmetric && out_q.bad_query))
    else $error("symmetric reported together with bad_query");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_valid_q && s1_valid_q && s1_last_q))
    else $error("input stalled without a waiting result");

  a_last_clears_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.data.last_word) |=> (cnt_q == '0))
    else $error("block counter not cleared after table end");

endmodule
